>>> hw/rtl/stls_pkg.sv
// Package of shared constants and types for the spike-triggered lag sum block.
package stls_pkg;

  // Depth of the stimulus and spike stores.
  localparam int SAMPLES = 16384;
  localparam int ADDR_W  = $clog2(SAMPLES);
  // Length counter can hold the depth itself.
  localparam int LEN_W   = ADDR_W + 1;
  // Field widths fixed by the interface.
  localparam int CFG_W   = 15;
  localparam int IDX_W   = 14;
  localparam int SAMP_W  = 16;
  localparam int CNT_W   = 16;
  localparam int LAG_W   = 15;
  localparam int SUM_W   = 32;
  // Accumulator: one sample per position, plus a sign bit of headroom.
  localparam int ACC_W   = SAMP_W + ADDR_W + 1;
  // Shifted position: counter plus lag, signed.
  localparam int POS_W   = LEN_W + 2;
  // Length after reset.
  localparam logic [CFG_W-1:0] LEN_RESET = CFG_W'(10001);

  // Operation codes.
  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  // Query sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_FINISH
  } state_t;

endpackage

>>> hw/rtl/spike_triggered_lag_sum.sv
// Spike-triggered lag sum: stores, sequencer, accumulator and result register.
//
// Usage: the input channel (in_valid / in_stall) carries load and query requests.
// A load writes one stimulus sample and one spike flag at an index and leaves
// the input channel open. A query walks every position below n once through
// one shared adder, one position per cycle, where n is signal_length capped
// at the store depth; that rate is set by the single read port of each store.
// in_stall stays high while a query is worked. Its result (lag_echo, lag_sum)
// appears on the output channel (out_valid / out_stall) and is held in an
// output register until taken; a stalled result only delays the end of the
// next query. Loads produce no result. signal_length is written through
// cfg_valid / cfg_ready / cfg_data; the user must do so only while the block
// is idle, which the block itself does not enforce. Reset (rst, synchronous)
// returns the sequencer to idle, drops out_valid and sets signal_length to
// 10001; the stores are not cleared and no clearing pass runs, so every
// position must be loaded before it is used.
module spike_triggered_lag_sum (
  input  logic                           clk,
  input  logic                           rst,
  // Input requests
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           operation,
  input  logic [stls_pkg::IDX_W-1:0]     index,
  input  logic signed [stls_pkg::SAMP_W-1:0] stimulus_sample,
  input  logic [stls_pkg::CNT_W-1:0]     spike_count,
  input  logic signed [stls_pkg::LAG_W-1:0] lag,
  // Results
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [stls_pkg::LAG_W-1:0] lag_echo,
  output logic signed [stls_pkg::SUM_W-1:0] lag_sum,
  // Configuration
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [stls_pkg::CFG_W-1:0]     cfg_data
);
  import stls_pkg::*;

  state_t                    state;
  state_t                    state_next;
  logic [CFG_W-1:0]          signal_length;
  logic [LEN_W-1:0]          len_eff;
  logic [LEN_W-1:0]          j;
  logic signed [LAG_W-1:0]   lag_q;
  logic signed [POS_W-1:0]   pos;
  logic                      pos_ok;
  logic                      last_pos;
  logic                      in_acc;
  logic                      start_query;
  logic                      finish_go;
  logic                      issue;
  logic                      pipe_ok;
  logic                      flag_rd;
  logic signed [SAMP_W-1:0]  stim_rd;
  logic signed [ACC_W-1:0]   acc;

  logic signed [SAMP_W-1:0]  stim_mem [SAMPLES];
  logic                      flag_mem [SAMPLES];

  assign cfg_ready = 1'b1;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      signal_length <= LEN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      signal_length <= cfg_data;
    end
  end

  // Effective length saturates at the store depth.
  always_comb begin
    if (LEN_W'(signal_length) > LEN_W'(SAMPLES)) begin
      len_eff = LEN_W'(SAMPLES);
    end else begin
      len_eff = LEN_W'(signal_length);
    end
  end

  // Shifted position and its range check.
  assign pos      = $signed({2'b00, j}) + POS_W'(lag_q);
  assign pos_ok   = !pos[POS_W-1] && (LEN_W'(pos) < len_eff);
  assign last_pos = (j + LEN_W'(1)) == len_eff;

  assign in_acc      = in_valid && !in_stall;
  assign start_query = in_acc && (operation == OP_QUERY);

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start_query) begin
          state_next = (len_eff == '0) ? ST_FINISH : ST_RUN;
        end
      end
      ST_RUN: begin
        if (last_pos) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid || !out_stall) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_stall  = 1'b1;
    issue     = 1'b0;
    finish_go = 1'b0;
    unique case (state)
      ST_IDLE:   in_stall = 1'b0;
      ST_RUN:    issue = 1'b1;
      ST_DRAIN:  ;
      ST_FINISH: finish_go = !out_valid || !out_stall;
      default:   ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Stores: written by a load, read one position a cycle during a query.
  always_ff @(posedge clk) begin
    if (in_acc && (operation == OP_LOAD)) begin
      stim_mem[index[ADDR_W-1:0]] <= stimulus_sample;
    end
    stim_rd <= stim_mem[pos[ADDR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (in_acc && (operation == OP_LOAD)) begin
      flag_mem[index[ADDR_W-1:0]] <= (spike_count != '0);
    end
    flag_rd <= flag_mem[j[ADDR_W-1:0]];
  end

  // Position counter and lag of the current query.
  always_ff @(posedge clk) begin
    if (rst) begin
      j       <= '0;
      pipe_ok <= 1'b0;
    end else begin
      pipe_ok <= issue && pos_ok;
      if (start_query) begin
        j <= '0;
      end else if (issue) begin
        j <= j + LEN_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start_query) begin
      lag_q <= lag;
    end
  end

  // Shared accumulator, fed in the cycle after the reads.
  always_ff @(posedge clk) begin
    if (start_query) begin
      acc <= '0;
    end else if (pipe_ok && flag_rd) begin
      acc <= acc + ACC_W'(stim_rd);
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish_go) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish_go) begin
      lag_echo <= lag_q;
      lag_sum  <= SUM_W'(acc);
    end
  end

  // A query request always starts the walk or ends at once on an empty length.
  a_query_start: assert property (@(posedge clk) disable iff (rst)
    start_query |=> (state == ST_RUN || state == ST_FINISH))
    else $error("query request did not start the sequencer");

  // The counter never walks past the effective length.
  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) |-> (j < len_eff))
    else $error("position counter beyond signal length");

  // Nothing is left in the read pipeline when the sum is taken.
  a_pipe_empty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINISH) |-> !pipe_ok)
    else $error("accumulator still busy at finish");

  // A new result only comes from the finishing state.
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == ST_FINISH))
    else $error("result raised outside finish");

endmodule

>>> tb/tb.sv
// Self-checking testbench for the spike-triggered lag sum block.
`timescale 1ns / 100ps

module tb;
  import stls_pkg::*;

  // Cycles without any accepted request before the run is abandoned.
  localparam int WATCHDOG_LIMIT = 100000;
  localparam int HOLD_CYCLES    = 400;
  // Positions loaded up front; every length used stays within them.
  localparam int FILL_DEPTH     = 32;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_RANDOM,
    STALL_PERIODIC
  } stall_style_t;

  typedef struct packed {
    logic signed [LAG_W-1:0] lag;
    logic signed [SUM_W-1:0] sum;
  } lag_result_t;

  logic                     clk = 1'b0;
  logic                     rst;
  logic                     in_valid;
  logic                     in_stall;
  logic                     operation;
  logic [IDX_W-1:0]         index;
  logic signed [SAMP_W-1:0] stimulus_sample;
  logic [CNT_W-1:0]         spike_count;
  logic signed [LAG_W-1:0]  lag;
  logic                     out_valid;
  logic                     out_stall;
  logic signed [LAG_W-1:0]  lag_echo;
  logic signed [SUM_W-1:0]  lag_sum;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [CFG_W-1:0]         cfg_data;

  // Shadow copy of the block's stores and length register.
  logic signed [SAMP_W-1:0] stim_mem [SAMPLES];
  logic                     spike_mem [SAMPLES];
  logic [CFG_W-1:0]         len_reg;

  // Lag sums still to come out, oldest first.
  lag_result_t expected_sums [$];

  stall_style_t stall_style   = STALL_RANDOM;
  int           hold_request  = 0;
  bit           gaps_enabled  = 1'b1;
  bit           offering      = 1'b0;
  int           burst_left    = 1;
  int           fail_count    = 0;
  int           loads_sent    = 0;
  int           queries_sent  = 0;
  int           sums_checked  = 0;
  int           length_writes = 0;
  int           quiet_cycles  = 0;

  spike_triggered_lag_sum u_dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .operation       (operation),
    .index           (index),
    .stimulus_sample (stimulus_sample),
    .spike_count     (spike_count),
    .lag             (lag),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .lag_echo        (lag_echo),
    .lag_sum         (lag_sum),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data)
  );

  always #10 clk = ~clk;

  // Sum of the shifted stimulus at every flagged position for the current length, clamped to 32 bits.
  function automatic logic signed [SUM_W-1:0] predict_lag_sum(
    input logic signed [LAG_W-1:0] shift
  );
    int      n;
    int      pos;
    longint  acc;
    n   = (int'(len_reg) > SAMPLES) ? SAMPLES : int'(len_reg);
    acc = 0;
    for (int j = 0; j < n; j++) begin
      pos = j + shift;
      if (pos >= 0 && pos < n && spike_mem[j]) begin
        acc += stim_mem[pos];
      end
    end
    if (acc > 64'sd2147483647) acc = 64'sd2147483647;
    if (acc < -64'sd2147483648) acc = -64'sd2147483648;
    return acc[SUM_W-1:0];
  endfunction

  // Offer one request, wait for it to be taken, update the shadow state and
  // then either keep the burst going or drop valid for a random gap.
  task automatic send_item(
    input op_t                      op,
    input logic [IDX_W-1:0]         idx,
    input logic signed [SAMP_W-1:0] samp,
    input logic [CNT_W-1:0]         cnt,
    input logic signed [LAG_W-1:0]  shift
  );
    int          gap;
    lag_result_t entry;
    operation       <= op;
    index           <= idx;
    stimulus_sample <= samp;
    spike_count     <= cnt;
    lag             <= shift;
    in_valid        <= 1'b1;
    offering = 1'b1;
    do @(posedge clk); while (in_stall);
    if (op == OP_LOAD) begin
      stim_mem[idx]  = samp;
      spike_mem[idx] = (cnt != '0);
      loads_sent++;
    end else begin
      entry.lag = shift;
      entry.sum = predict_lag_sum(shift);
      expected_sums.insert(expected_sums.size(), entry);
      queries_sent++;
    end
    @(negedge clk);
    if (gaps_enabled) begin
      if (burst_left > 1) begin
        burst_left--;
      end else begin
        in_valid <= 1'b0;
        offering = 1'b0;
        gap = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 5) : $urandom_range(10, 30);
        repeat (gap) @(negedge clk);
        burst_left = $urandom_range(1, 12);
      end
    end
  endtask

  // A load with a random, unused lag field.
  task automatic load_sample(
    input logic [IDX_W-1:0]         idx,
    input logic signed [SAMP_W-1:0] samp,
    input logic [CNT_W-1:0]         cnt
  );
    send_item(OP_LOAD, idx, samp, cnt, LAG_W'($urandom));
  endtask

  // A query with random, unused load fields.
  task automatic query_lag(input logic signed [LAG_W-1:0] shift);
    send_item(OP_QUERY, IDX_W'($urandom), SAMP_W'($urandom), CNT_W'($urandom), shift);
  endtask

  task automatic release_input();
    if (offering) begin
      in_valid <= 1'b0;
      offering = 1'b0;
    end
  endtask

  // Change the signal length once every sum is out and the block has settled.
  task automatic write_length(input logic [CFG_W-1:0] value);
    release_input();
    while (expected_sums.size() != 0) @(negedge clk);
    // A trailing load produces no result, so leave it time to finish.
    repeat (8) @(negedge clk);
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    len_reg = value;
    length_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // The first FILL_DEPTH positions are written once, and no length used goes
  // beyond them, so that no query reads an unloaded entry.
  task automatic fill_store();
    logic [CNT_W-1:0] cnt;
    for (int i = 0; i < FILL_DEPTH; i++) begin
      cnt = $urandom_range(0, 1) ? CNT_W'($urandom) : '0;
      load_sample(IDX_W'(i), SAMP_W'($urandom), cnt);
    end
  endtask

  // Queries at the usual sweep bounds over the loaded window.
  task automatic test_sweep_bounds();
    write_length(CFG_W'(FILL_DEPTH));
    query_lag(LAG_W'(0));
    query_lag(LAG_W'(-500));
    query_lag(LAG_W'(10000));
  endtask

  // Extreme samples, indices and lags.
  task automatic test_field_extremes();
    load_sample('0, 16'sh8000, 16'hFFFF);
    load_sample('1, 16'sh7FFF, 16'h0001);
    load_sample(IDX_W'(1), 16'sh0000, 16'h0000);
    query_lag(LAG_W'(-16384));
    query_lag(LAG_W'(16383));
    query_lag(LAG_W'(0));
  endtask

  // An empty sum and a single-position sum.
  task automatic test_short_lengths();
    write_length('0);
    query_lag(LAG_W'(0));
    query_lag(LAG_W'(-3));
    write_length(CFG_W'(1));
    query_lag(LAG_W'(0));
    load_sample('0, 16'sh0123, 16'h0040);
    query_lag(LAG_W'(0));
    query_lag(LAG_W'(1));
  endtask

  // Phases of random loads and queries, mostly aimed inside the active window.
  task automatic test_random_traffic();
    int                       n;
    int                       span;
    logic [IDX_W-1:0]         idx;
    logic signed [SAMP_W-1:0] samp;
    logic [CNT_W-1:0]         cnt;
    logic signed [LAG_W-1:0]  shift;
    for (int p = 0; p < 3; p++) begin
      n = (p == 2) ? FILL_DEPTH : $urandom_range(2, FILL_DEPTH);
      write_length(CFG_W'(n));
      gaps_enabled = (p != 1);
      stall_style  = stall_style_t'(p % 3);
      for (int k = 0; k < 16; k++) begin
        if ($urandom_range(0, 99) < 55) begin
          idx  = ($urandom_range(0, 3) != 0) ? IDX_W'($urandom_range(0, n - 1))
                                             : IDX_W'($urandom);
          samp = ($urandom_range(0, 9) == 0) ? ($urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000)
                                             : SAMP_W'($urandom);
          cnt  = ($urandom_range(0, 99) < 40) ? '0 :
                 ($urandom_range(0, 9) == 0) ? '1 : CNT_W'($urandom);
          load_sample(idx, samp, cnt);
        end else begin
          span  = n + 2;
          shift = ($urandom_range(0, 4) == 0) ? LAG_W'($urandom)
                  : LAG_W'(int'($urandom_range(0, 2 * span)) - span);
          query_lag(shift);
        end
      end
    end
  endtask

  // The receiver holds off for a long stretch while queries keep arriving.
  task automatic test_backpressure();
    write_length(CFG_W'(16));
    gaps_enabled = 1'b0;
    stall_style  = STALL_NONE;
    hold_request = HOLD_CYCLES;
    for (int k = 0; k < 6; k++) begin
      query_lag(LAG_W'(k - 3));
      if (k == 2) load_sample(IDX_W'(5), SAMP_W'($urandom), 16'h0007);
    end
    release_input();
    gaps_enabled = 1'b1;
    stall_style  = STALL_RANDOM;
  endtask

  // Result checker: every taken result must match the oldest expected sum.
  always @(posedge clk) begin : check_results
    lag_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_sums.size() == 0) begin
        $error("unexpected result: lag_echo=%0d lag_sum=%0d", lag_echo, lag_sum);
        fail_count++;
      end else begin
        want = expected_sums.pop_front();
        sums_checked++;
        if (lag_echo !== want.lag) begin
          $error("lag_echo: expected %0d, got %0d", want.lag, lag_echo);
          fail_count++;
        end
        if (lag_sum !== want.sum) begin
          $error("lag_sum: expected %0d, got %0d", want.sum, lag_sum);
          fail_count++;
        end
      end
    end
  end

  // Receiver stall pattern, with an occasional long hold-off on request.
  initial begin : receiver
    int tick;
    tick      = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request != 0) begin
        out_stall <= 1'b1;
        repeat (hold_request) @(negedge clk);
        hold_request = 0;
      end
      tick++;
      case (stall_style)
        STALL_NONE:     out_stall <= 1'b0;
        STALL_RANDOM:   out_stall <= ($urandom_range(0, 99) < 35);
        STALL_PERIODIC: out_stall <= ((tick % 5) >= 3);
        default:        out_stall <= 1'b0;
      endcase
    end
  end

  // Watchdog on cycles in which no channel moves a request.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $error("watchdog: no request moved for %0d cycles", WATCHDOG_LIMIT);
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    rst             = 1'b1;
    in_valid        = 1'b0;
    operation       = OP_LOAD;
    index           = '0;
    stimulus_sample = '0;
    spike_count     = '0;
    lag             = '0;
    cfg_valid       = 1'b0;
    cfg_data        = '0;
    len_reg         = LEN_RESET;
    for (int i = 0; i < SAMPLES; i++) begin
      stim_mem[i]  = '0;
      spike_mem[i] = 1'b0;
    end
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    fill_store();
    test_sweep_bounds();
    test_field_extremes();
    test_short_lengths();
    test_random_traffic();
    test_backpressure();

    // Drain the remaining sums, then allow the block to settle.
    release_input();
    while (expected_sums.size() != 0) @(negedge clk);
    repeat (20) @(posedge clk);

    $display("summary: %0d loads and %0d queries sent, %0d lag sums checked",
             loads_sent, queries_sent, sums_checked);
    $display("summary: %0d signal length settings, with and without stalls and gaps",
             length_writes);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
